>>> rtl/cpsd_pkg.sv
`timescale 1ns / 1ps

package cpsd_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int RW    = CW - 1;      // radius width
    localparam int DW    = CW + 1;      // coordinate difference width
    localparam int PW    = 2 * DW;      // square / product width
    localparam int DOTW  = PW + 2;      // signed dot product width
    localparam int RTW   = DW;          // square root width
    localparam int NSQ   = PW / 2;      // square root steps
    localparam int REMW  = RTW + 3;     // square root remainder width
    localparam int QW    = DW + 2;      // axial quotient width
    localparam int DN2W  = 2 * QW;      // squared axial distance width
    localparam int SIDEW = RTW + 1;     // side wall distance width
    localparam int CAPW  = QW + 1;      // cap distance width
    localparam int DISTW = 32;          // result distance width
    localparam int IDXW  = 3;           // register index width
    localparam int IN_TW  = 3 * CW;
    localparam int OUT_TW = ((DISTW + 2 + 7) / 8) * 8;

    typedef enum logic [IDXW-1:0] {
        REG_BASE_X = 3'd0,
        REG_BASE_Y = 3'd1,
        REG_BASE_Z = 3'd2,
        REG_TOP_X  = 3'd3,
        REG_TOP_Y  = 3'd4,
        REG_TOP_Z  = 3'd5,
        REG_RADIUS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [RTW-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic [RTW-1:0] rem;
        logic [QW-1:0]  q;
    } dv_t;

    // carried through the axis length root
    typedef struct packed {
        logic [PW-1:0] dd;
        logic [PW-1:0] dmag;
        logic          dotneg;
        logic          between;
        logic          empty;
    } axc_t;

    // carried through the axial division
    typedef struct packed {
        logic [PW-1:0]  dd;
        logic [PW-1:0]  dmag;
        logic [RTW-1:0] ln;
        logic           dotneg;
        logic           between;
        logic           empty;
    } dvc_t;

    // carried through the radial root
    typedef struct packed {
        logic [QW-1:0]  dnmag;
        logic [RTW-1:0] ln;
        logic           dotneg;
        logic           between;
        logic           empty;
    } pc_t;

    typedef struct packed {
        logic [SIDEW-1:0] side;
        logic [QW-1:0]    c0;
        logic [CAPW-1:0]  c1;
        logic             between;
        logic             in_radius;
        logic             empty;
    } fin_t;

    typedef struct packed {
        logic             in_solid;
        logic             valid;
        logic [DISTW-1:0] distance;
    } res_t;

    // one digit of a restoring square root: two radicand bits in, one root bit out
    function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
        logic [REMW-1:0] r;
        logic [REMW-1:0] t;
        sq_t             o;
        r = {s.rem[REMW-3:0], pair};
        t = {1'b0, s.root, 2'b01};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {s.root[RTW-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[RTW-2:0], 1'b0};
        end
        return o;
    endfunction

    // one bit of a restoring division
    function automatic dv_t div_step(dv_t s, logic nbit, logic [RTW-1:0] den);
        logic [RTW:0] t;
        logic         ge;
        dv_t          o;
        t  = {s.rem, nbit};
        ge = (t >= {1'b0, den});
        o.rem = ge ? RTW'(t - {1'b0, den}) : RTW'(t);
        o.q   = {s.q[QW-2:0], ge};
        return o;
    endfunction

endpackage

>>> rtl/cylinder_point_surface_distance.sv
`timescale 1ns / 1ps

// Point to finite cylinder surface distance.
// Configure the cylinder through the write port (cfg_wr_en, cfg_wr_index,
// cfg_wr_data): index 0..2 base centre x/y/z, 3..5 top centre x/y/z, 6 radius,
// all Q16.16. Write only while no point is in flight.
// Points enter on the s_ stream, one transfer per point; each point gives
// exactly one result transfer on the m_ stream, in order.
// Pipeline from input transfer to m_tvalid: 3 stages form the
// squares and the dot product, 33 stages take the axis length root, 35 stages
// divide for the axial position, 2 stages form the radial square, 33 stages
// take the radial root, then one compare stage and the output register.
// Throughput is one point per cycle while the receiver does not stall: every unit is fully pipelined.
// Reset clears all valid bits and loads the default cylinder (base at the
// origin, top at z = 1.0, radius 1.0).
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; s_tready then drops and the whole pipeline freezes
// until the skid register drains. Nothing is lost or repeated.
module cylinder_point_surface_distance (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpsd_pkg::IDXW-1:0]     cfg_wr_index,
    input  logic [cpsd_pkg::CW-1:0]       cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cpsd_pkg::IN_TW-1:0]    s_tdata,   // point_x, point_y, point_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cpsd_pkg::OUT_TW-1:0]   m_tdata    // surface_distance, distance_valid,
                                                     // point_inside, zero fill
);

    localparam int CW    = cpsd_pkg::CW;
    localparam int DW    = cpsd_pkg::DW;
    localparam int PW    = cpsd_pkg::PW;
    localparam int DOTW  = cpsd_pkg::DOTW;
    localparam int RTW   = cpsd_pkg::RTW;
    localparam int NSQ   = cpsd_pkg::NSQ;
    localparam int QW    = cpsd_pkg::QW;
    localparam int DN2W  = cpsd_pkg::DN2W;
    localparam int SIDEW = cpsd_pkg::SIDEW;
    localparam int CAPW  = cpsd_pkg::CAPW;
    localparam int DISTW = cpsd_pkg::DISTW;
    localparam int RW    = cpsd_pkg::RW;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] base_x_reg, base_y_reg, base_z_reg;
    logic signed [CW-1:0] top_x_reg, top_y_reg, top_z_reg;
    logic [RW-1:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            base_z_reg <= '0;
            top_x_reg  <= '0;
            top_y_reg  <= '0;
            top_z_reg  <= CW'(65536);
            radius_reg <= RW'(65536);
        end else if (cfg_wr_en) begin
            unique case (cpsd_pkg::cfg_reg_t'(cfg_wr_index))
                cpsd_pkg::REG_BASE_X: base_x_reg <= cfg_wr_data;
                cpsd_pkg::REG_BASE_Y: base_y_reg <= cfg_wr_data;
                cpsd_pkg::REG_BASE_Z: base_z_reg <= cfg_wr_data;
                cpsd_pkg::REG_TOP_X:  top_x_reg  <= cfg_wr_data;
                cpsd_pkg::REG_TOP_Y:  top_y_reg  <= cfg_wr_data;
                cpsd_pkg::REG_TOP_Z:  top_z_reg  <= cfg_wr_data;
                cpsd_pkg::REG_RADIUS: radius_reg <= cfg_wr_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // axis vector; the user must keep the configuration stable while points are in flight (not enforced here)
    logic signed [DW-1:0] ax, ay, az;
    assign ax = DW'(top_x_reg) - DW'(base_x_reg);
    assign ay = DW'(top_y_reg) - DW'(base_y_reg);
    assign az = DW'(top_z_reg) - DW'(base_z_reg);

    // ---------------- flow control ----------------
    logic skid_v_reg;
    logic out_v_reg;
    logic en;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // ---------------- stage 1: differences ----------------
    logic                 p1_v_reg;
    logic signed [DW-1:0] p1_dx_reg, p1_dy_reg, p1_dz_reg;
    logic signed [CW-1:0] pt_x, pt_y, pt_z;

    assign pt_x = s_tdata[CW-1:0];
    assign pt_y = s_tdata[2*CW-1:CW];
    assign pt_z = s_tdata[3*CW-1:2*CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (en) begin
            p1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_dx_reg <= DW'(pt_x) - DW'(base_x_reg);
            p1_dy_reg <= DW'(pt_y) - DW'(base_y_reg);
            p1_dz_reg <= DW'(pt_z) - DW'(base_z_reg);
        end
    end

    // ---------------- stage 2: products ----------------
    logic                 p2_v_reg;
    logic signed [PW-1:0] p2_ddx_reg, p2_ddy_reg, p2_ddz_reg;
    logic signed [PW-1:0] p2_dax_reg, p2_day_reg, p2_daz_reg;
    logic signed [PW-1:0] p2_aax_reg, p2_aay_reg, p2_aaz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (en) begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_ddx_reg <= p1_dx_reg * p1_dx_reg;
            p2_ddy_reg <= p1_dy_reg * p1_dy_reg;
            p2_ddz_reg <= p1_dz_reg * p1_dz_reg;
            p2_dax_reg <= p1_dx_reg * ax;
            p2_day_reg <= p1_dy_reg * ay;
            p2_daz_reg <= p1_dz_reg * az;
            p2_aax_reg <= ax * ax;
            p2_aay_reg <= ay * ay;
            p2_aaz_reg <= az * az;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic                   p3_v_reg;
    logic [PW-1:0]          p3_dd_reg, p3_aa_reg;
    logic signed [DOTW-1:0] p3_dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (en) begin
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_dd_reg  <= p2_ddx_reg + p2_ddy_reg + p2_ddz_reg;
            p3_aa_reg  <= p2_aax_reg + p2_aay_reg + p2_aaz_reg;
            p3_dot_reg <= DOTW'(p2_dax_reg) + DOTW'(p2_day_reg) + DOTW'(p2_daz_reg);
        end
    end

    // ---------------- axis length root ----------------
    logic                 dot_neg;
    logic [DOTW-1:0]      dot_abs;
    cpsd_pkg::axc_t       head_c;

    assign dot_neg = p3_dot_reg[DOTW-1];
    assign dot_abs = dot_neg ? DOTW'(-p3_dot_reg) : DOTW'(p3_dot_reg);

    always_comb begin
        head_c.dd      = p3_dd_reg;
        head_c.dmag    = dot_abs[PW-1:0];
        head_c.dotneg  = dot_neg;
        head_c.between = !dot_neg && (dot_abs[PW-1:0] <= p3_aa_reg);
        head_c.empty   = (p3_aa_reg == '0);
    end

    logic           s1_v_reg   [NSQ];
    cpsd_pkg::sq_t  s1_sq_reg  [NSQ];
    logic [PW-1:0]  s1_rad_reg [NSQ];
    cpsd_pkg::axc_t s1_c_reg   [NSQ];

    for (genvar k = 0; k < NSQ; k++) begin : g_sq1
        logic           in_v;
        cpsd_pkg::sq_t  in_sq;
        logic [PW-1:0]  in_rad;
        cpsd_pkg::axc_t in_c;

        if (k == 0) begin : g_head
            assign in_v   = p3_v_reg;
            assign in_sq  = '0;
            assign in_rad = p3_aa_reg;
            assign in_c   = head_c;
        end else begin : g_body
            assign in_v   = s1_v_reg[k-1];
            assign in_sq  = s1_sq_reg[k-1];
            assign in_rad = s1_rad_reg[k-1];
            assign in_c   = s1_c_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s1_v_reg[k] <= 1'b0;
            end else if (en) begin
                s1_v_reg[k] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s1_sq_reg[k]  <= cpsd_pkg::sq_step(in_sq, in_rad[PW-1-2*k -: 2]);
                s1_rad_reg[k] <= in_rad;
                s1_c_reg[k]   <= in_c;
            end
        end
    end

    // ---------------- axial division ----------------
    cpsd_pkg::dvc_t dv_head_c;
    cpsd_pkg::dv_t  dv_head;

    always_comb begin
        dv_head_c.dd      = s1_c_reg[NSQ-1].dd;
        dv_head_c.dmag    = s1_c_reg[NSQ-1].dmag;
        dv_head_c.ln      = s1_sq_reg[NSQ-1].root;
        dv_head_c.dotneg  = s1_c_reg[NSQ-1].dotneg;
        dv_head_c.between = s1_c_reg[NSQ-1].between;
        dv_head_c.empty   = s1_c_reg[NSQ-1].empty;
        // the quotient fits QW bits, so the top bits already sit below the divisor
        dv_head.rem       = RTW'(s1_c_reg[NSQ-1].dmag[PW-1:QW]);
        dv_head.q         = '0;
    end

    logic           dv_v_reg [QW];
    cpsd_pkg::dv_t  dv_reg   [QW];
    cpsd_pkg::dvc_t dv_c_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic           in_v;
        cpsd_pkg::dv_t  in_dv;
        cpsd_pkg::dvc_t in_c;

        if (j == 0) begin : g_head
            assign in_v  = s1_v_reg[NSQ-1];
            assign in_dv = dv_head;
            assign in_c  = dv_head_c;
        end else begin : g_body
            assign in_v  = dv_v_reg[j-1];
            assign in_dv = dv_reg[j-1];
            assign in_c  = dv_c_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[j]   <= cpsd_pkg::div_step(in_dv, in_c.dmag[QW-1-j], in_c.ln);
                dv_c_reg[j] <= in_c;
            end
        end
    end

    // ---------------- axial square and radial remainder ----------------
    logic            m_v_reg;
    logic [DN2W-1:0] m_dn2_reg;
    logic [PW-1:0]   m_dd_reg;
    cpsd_pkg::pc_t   m_pc_reg;
    logic [QW-1:0]   dnmag;

    assign dnmag = dv_reg[QW-1].q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (en) begin
            m_v_reg <= dv_v_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_dn2_reg        <= dnmag * dnmag;
            m_dd_reg         <= dv_c_reg[QW-1].dd;
            m_pc_reg.dnmag   <= dnmag;
            m_pc_reg.ln      <= dv_c_reg[QW-1].ln;
            m_pc_reg.dotneg  <= dv_c_reg[QW-1].dotneg;
            m_pc_reg.between <= dv_c_reg[QW-1].between;
            m_pc_reg.empty   <= dv_c_reg[QW-1].empty;
        end
    end

    logic            r_v_reg;
    logic [PW-1:0]   r_rad_reg;
    cpsd_pkg::pc_t   r_pc_reg;
    logic [DN2W-1:0] dd_ext;

    assign dd_ext = DN2W'(m_dd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_v_reg <= 1'b0;
        end else if (en) begin
            r_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_rad_reg <= (dd_ext > m_dn2_reg) ? PW'(dd_ext - m_dn2_reg) : '0;
            r_pc_reg  <= m_pc_reg;
        end
    end

    // ---------------- radial root ----------------
    logic          s2_v_reg   [NSQ];
    cpsd_pkg::sq_t s2_sq_reg  [NSQ];
    logic [PW-1:0] s2_rad_reg [NSQ];
    cpsd_pkg::pc_t s2_pc_reg  [NSQ];

    for (genvar k = 0; k < NSQ; k++) begin : g_sq2
        logic          in_v;
        cpsd_pkg::sq_t in_sq;
        logic [PW-1:0] in_rad;
        cpsd_pkg::pc_t in_pc;

        if (k == 0) begin : g_head
            assign in_v   = r_v_reg;
            assign in_sq  = '0;
            assign in_rad = r_rad_reg;
            assign in_pc  = r_pc_reg;
        end else begin : g_body
            assign in_v   = s2_v_reg[k-1];
            assign in_sq  = s2_sq_reg[k-1];
            assign in_rad = s2_rad_reg[k-1];
            assign in_pc  = s2_pc_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s2_v_reg[k] <= 1'b0;
            end else if (en) begin
                s2_v_reg[k] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s2_sq_reg[k]  <= cpsd_pkg::sq_step(in_sq, in_rad[PW-1-2*k -: 2]);
                s2_rad_reg[k] <= in_rad;
                s2_pc_reg[k]  <= in_pc;
            end
        end
    end

    // ---------------- candidate distances ----------------
    logic                    f_v_reg;
    cpsd_pkg::fin_t          f_reg;
    cpsd_pkg::fin_t          f_next;
    cpsd_pkg::pc_t           lpc;
    logic [RTW-1:0]          dax;
    logic signed [SIDEW-1:0] side_diff;

    assign lpc       = s2_pc_reg[NSQ-1];
    assign dax       = s2_sq_reg[NSQ-1].root;
    assign side_diff = $signed(SIDEW'(radius_reg)) - $signed(SIDEW'(dax));

    always_comb begin
        f_next.side    = side_diff[SIDEW-1] ? SIDEW'(-side_diff) : SIDEW'(side_diff);
        f_next.c0      = lpc.dnmag;
        // distance to the top cap plane
        if (lpc.dotneg) begin
            f_next.c1 = CAPW'(lpc.ln) + CAPW'(lpc.dnmag);
        end else if (CAPW'(lpc.ln) >= CAPW'(lpc.dnmag)) begin
            f_next.c1 = CAPW'(lpc.ln) - CAPW'(lpc.dnmag);
        end else begin
            f_next.c1 = CAPW'(lpc.dnmag) - CAPW'(lpc.ln);
        end
        f_next.between   = lpc.between;
        f_next.in_radius = (dax <= RTW'(radius_reg));
        f_next.empty     = lpc.empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (en) begin
            f_v_reg <= s2_v_reg[NSQ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
        end
    end

    // ---------------- result selection ----------------
    cpsd_pkg::res_t  res;
    logic [CAPW-1:0] cap;
    logic [CAPW-1:0] best;

    always_comb begin
        cap = (CAPW'(f_reg.c0) < f_reg.c1) ? CAPW'(f_reg.c0) : f_reg.c1;
        if (f_reg.between && f_reg.in_radius) begin
            best = (CAPW'(f_reg.side) < cap) ? CAPW'(f_reg.side) : cap;
        end else if (f_reg.between) begin
            best = CAPW'(f_reg.side);
        end else begin
            best = cap;
        end
        res.valid    = !f_reg.empty && (f_reg.between || f_reg.in_radius);
        res.in_solid = !f_reg.empty && f_reg.between && f_reg.in_radius;
        if (!res.valid) begin
            res.distance = '0;
        end else if (best > CAPW'({DISTW{1'b1}})) begin
            res.distance = '1;
        end else begin
            res.distance = best[DISTW-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    cpsd_pkg::res_t out_reg;
    cpsd_pkg::res_t skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= f_v_reg;
            end
        end else if (f_v_reg && en) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end else if (f_v_reg && en) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = cpsd_pkg::OUT_TW'(out_reg);

    // ---------------- checks ----------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds data while output register is empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !skid_v_reg ##1 skid_v_reg |-> $past(out_v_reg && !m_tready))
        else $error("skid register filled without a stalled output");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |=> $stable(p1_v_reg) && $stable(f_v_reg))
        else $error("pipeline moved while the skid register was full");

    a_inside_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_reg.in_solid |-> out_reg.valid)
        else $error("inside point without an applicable surface");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && !out_reg.valid |-> out_reg.distance == '0)
        else $error("distance nonzero with no applicable surface");

endmodule

>>> tb/cylinder_point_surface_distance_test.sv
`timescale 1ns / 1ps

module cylinder_point_surface_distance_test;

    localparam logic [cpsd_pkg::IDXW-1:0] REG_UNUSED = 3'd7;
    localparam int LATENCY = 108;

    typedef logic signed [127:0] wide_t;

    class distance_scoreboard;
        longint           cyl_base[3];
        longint           cyl_top[3];
        longint           cyl_radius;
        cpsd_pkg::res_t   pending[$];
        int               mismatches;

        function new();
            cyl_base = '{0, 0, 0};
            cyl_top  = '{0, 0, 65536};
            cyl_radius = 65536;
            mismatches = 0;
        endfunction

        function void set_reg(logic [cpsd_pkg::IDXW-1:0] idx, logic [31:0] val);
            case (idx)
                cpsd_pkg::REG_BASE_X: cyl_base[0] = longint'(signed'(val));
                cpsd_pkg::REG_BASE_Y: cyl_base[1] = longint'(signed'(val));
                cpsd_pkg::REG_BASE_Z: cyl_base[2] = longint'(signed'(val));
                cpsd_pkg::REG_TOP_X:  cyl_top[0]  = longint'(signed'(val));
                cpsd_pkg::REG_TOP_Y:  cyl_top[1]  = longint'(signed'(val));
                cpsd_pkg::REG_TOP_Z:  cyl_top[2]  = longint'(signed'(val));
                cpsd_pkg::REG_RADIUS: cyl_radius  = longint'({1'b0, val[30:0]});
                default: ;
            endcase
        endfunction

        function wide_t floor_root(wide_t n);
            wide_t r;
            wide_t c;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (wide_t'(1) << b);
                if (c * c <= n) r = c;
            end
            return r;
        endfunction

        function cpsd_pkg::res_t classify(logic [cpsd_pkg::IN_TW-1:0] pt);
            wide_t d[3], a[3];
            wide_t aa, dd, dot, dmag, dnmag, dn, ln, dax, rad2, side, c0, c1, best;
            logic  dotneg, between, in_radius, valid;
            cpsd_pkg::res_t r;
            aa = 0; dd = 0; dot = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = wide_t'(longint'(signed'(pt[32*i +: 32])) - cyl_base[i]);
                a[i] = wide_t'(cyl_top[i] - cyl_base[i]);
                aa += a[i] * a[i];
                dd += d[i] * d[i];
                dot += d[i] * a[i];
            end
            r = '0;
            if (aa == 0) return r;
            ln = floor_root(aa);
            dotneg = dot < 0;
            dmag = dotneg ? -dot : dot;
            dnmag = dmag / ln;
            between = !dotneg && dmag <= aa;
            rad2 = (dd > dnmag * dnmag) ? dd - dnmag * dnmag : 0;
            dax = floor_root(rad2);
            in_radius = dax <= wide_t'(cyl_radius);
            dn = dotneg ? -dnmag : dnmag;
            best = wide_t'(64'hFFFF_FFFF_FFFF_FFFF);
            valid = 0;
            if (between) begin
                side = wide_t'(cyl_radius) - dax;
                if (side < 0) side = -side;
                if (side < best) best = side;
                valid = 1;
            end
            if (in_radius) begin
                c0 = dnmag;
                c1 = ln - dn;
                if (c1 < 0) c1 = -c1;
                if (c1 < c0) c0 = c1;
                if (c0 < best) best = c0;
                valid = 1;
            end
            if (valid) begin
                r.distance = (best > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
                r.valid    = 1'b1;
            end
            r.in_solid = between && in_radius;
            return r;
        endfunction

        function void note_point(logic [cpsd_pkg::IN_TW-1:0] pt);
            pending = {pending, classify(pt)};
        endfunction

        function void check_result(cpsd_pkg::res_t got);
            cpsd_pkg::res_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with none expected: %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.distance !== exp_r.distance || got.valid !== exp_r.valid
                    || got.in_solid !== exp_r.in_solid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: dist %h/%h valid %b/%b inside %b/%b (exp/got)",
                             exp_r.distance, got.distance, exp_r.valid, got.valid,
                             exp_r.in_solid, got.in_solid);
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [cpsd_pkg::IDXW-1:0]     cfg_wr_index;
    logic [cpsd_pkg::CW-1:0]       cfg_wr_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cpsd_pkg::IN_TW-1:0]    s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cpsd_pkg::OUT_TW-1:0]   m_tdata;

    distance_scoreboard sb;
    int hold_cycles;
    int stall_pct;
    int burst_left;

    cylinder_point_surface_distance u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("cylinder_point_surface_distance_test: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_point(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(cpsd_pkg::res_t'(m_tdata[cpsd_pkg::DISTW+1:0]));
    end

    // receiver: random stalls at the current rate, plus a single long hold-off
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [cpsd_pkg::IDXW-1:0] idx, logic [31:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_cylinder(longint bx, longint by, longint bz,
                                longint tx, longint ty, longint tz, longint rad);
        write_reg(cpsd_pkg::REG_BASE_X, bx[31:0]);
        write_reg(cpsd_pkg::REG_BASE_Y, by[31:0]);
        write_reg(cpsd_pkg::REG_BASE_Z, bz[31:0]);
        write_reg(cpsd_pkg::REG_TOP_X, tx[31:0]);
        write_reg(cpsd_pkg::REG_TOP_Y, ty[31:0]);
        write_reg(cpsd_pkg::REG_TOP_Z, tz[31:0]);
        write_reg(cpsd_pkg::REG_RADIUS, rad[31:0]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // offer one point; valid stays high across back-to-back transfers within a burst
    task automatic send_point(longint px, longint py, longint pz);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {pz[31:0], py[31:0], px[31:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic longint jitter();
        longint v;
        v = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic random_points(int n);
        longint p[3];
        int k;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(10);
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(7) == 0)
                    p[i] = longint'(signed'($urandom()));
                else
                    p[i] = sb.cyl_base[i] + (sb.cyl_top[i] - sb.cyl_base[i]) * (k - 1) / 8
                           + jitter();
            end
            send_point(p[0], p[1], p[2]);
        end
    endtask

    function automatic longint rnd_coord(int bits);
        return longint'(signed'($urandom())) >>> (32 - bits);
    endfunction

    initial begin
        longint lo, hi;
        sb = new();
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_index = cpsd_pkg::REG_BASE_X;
        cfg_wr_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        hold_cycles = 0;
        stall_pct = 20;
        burst_left = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        // default unit cylinder: inside, on caps, on wall, beside, above, no surface
        send_point(0, 0, 0);
        send_point(0, 0, 65536);
        send_point(0, 0, 32768);
        send_point(65536, 0, 32768);
        send_point(131072, 0, 32768);
        send_point(0, 32768, -65536);
        send_point(0, 0, 200000);
        send_point(300000, 300000, 300000);
        send_point(300000, 0, -300000);
        send_point(lo, lo, lo);
        send_point(hi, hi, hi);
        send_point(lo, hi, 0);
        send_point(-1, -1, -1);
        wait_drained();

        // out-of-range index is ignored
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        // zero-length axis: empty cylinder
        set_cylinder(1000, -2000, 3000, 1000, -2000, 3000, 65536);
        send_point(1000, -2000, 3000);
        send_point(hi, lo, 7);
        send_point(0, 0, 0);
        wait_drained();
        // longest axis and widest radius: large distances saturate
        set_cylinder(lo, lo, lo, hi, hi, hi, hi);
        send_point(hi, lo, hi);
        send_point(lo, hi, lo);
        send_point(0, 0, 0);
        send_point(hi, hi, hi);
        wait_drained();
        set_cylinder(0, 0, 0, 0, 0, 65536, 0);
        send_point(0, 0, 100);
        send_point(lo, 0, 100);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
            case (ph % 4)
                0: set_cylinder(rnd_coord(20), rnd_coord(20), rnd_coord(20),
                                rnd_coord(20), rnd_coord(20), rnd_coord(20),
                                $urandom_range(0, 1 << 19));
                1: set_cylinder(rnd_coord(32), rnd_coord(32), rnd_coord(32),
                                rnd_coord(32), rnd_coord(32), rnd_coord(32),
                                $urandom() & 32'h7FFF_FFFF);
                2: set_cylinder(0, 0, 0, $urandom_range(1, 100000), 0, 0,
                                $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1 << 18));
                default: set_cylinder(rnd_coord(8), rnd_coord(8), rnd_coord(8),
                                      rnd_coord(8), rnd_coord(8), rnd_coord(8),
                                      $urandom_range(0, 300));
            endcase
            if (ph == 4) hold_cycles = 400;
            random_points(240);
            wait_drained();
        end

        stall_pct = 0;
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("cylinder_point_surface_distance_test: done, clean");
        else
            $display("cylinder_point_surface_distance_test: done, errors");
        $finish;
    end

endmodule
